>>> hw/rtl/kvtp_pkg.sv
package kvtp_pkg;

  // Opcodes of one input transaction
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Key lengths
  localparam int unsigned PRESS_KEY_LEN  = 11;
  localparam int unsigned HEIGHT_KEY_LEN = 9;

  // Magnitude cap: accumulators saturate at 2^31
  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  // Pressure parse phases
  localparam logic [1:0] PP_SEARCH = 2'd0;
  localparam logic [1:0] PP_BLANK  = 2'd1;
  localparam logic [1:0] PP_DIGITS = 2'd2;
  localparam logic [1:0] PP_DONE   = 2'd3;

  // Height parse phases
  localparam logic [2:0] HP_SEARCH = 3'd0;
  localparam logic [2:0] HP_BLANK  = 3'd1;
  localparam logic [2:0] HP_INT    = 3'd2;
  localparam logic [2:0] HP_FRAC   = 3'd3;
  localparam logic [2:0] HP_DONE   = 3'd4;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef logic [3:0] key_pos_t;

  // "Pressure = "
  function automatic logic [7:0] press_key_char(input key_pos_t pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = "P";
      4'd1:    ch = "r";
      4'd2:    ch = "e";
      4'd3:    ch = "s";
      4'd4:    ch = "s";
      4'd5:    ch = "u";
      4'd6:    ch = "r";
      4'd7:    ch = "e";
      4'd8:    ch = " ";
      4'd9:    ch = "=";
      4'd10:   ch = " ";
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  // "Height = "
  function automatic logic [7:0] height_key_char(input key_pos_t pos);
    logic [7:0] ch;
    case (pos)
      4'd0:    ch = "H";
      4'd1:    ch = "e";
      4'd2:    ch = "i";
      4'd3:    ch = "g";
      4'd4:    ch = "h";
      4'd5:    ch = "t";
      4'd6:    ch = " ";
      4'd7:    ch = "=";
      4'd8:    ch = " ";
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Magnitude plus sign to two's complement, clamping positive overflow
  function automatic logic [31:0] to_signed_bits(input logic [31:0] mag, input logic neg);
    logic [31:0] res;
    if (neg) begin
      res = 32'd0 - mag;
    end else if (mag >= MAG_CAP) begin
      res = POS_MAX;
    end else begin
      res = mag;
    end
    return res;
  endfunction

endpackage

>>> hw/rtl/kvtp_if.sv
interface kvtp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface kvtp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pressure_value;
  logic               pressure_found;
  logic signed [31:0] height_tenths;
  logic               height_found;

  modport source (output valid, output pressure_value, output pressure_found,
                  output height_tenths, output height_found, input ready);
  modport sink   (input valid, input pressure_value, input pressure_found,
                  input height_tenths, input height_found, output ready);
endinterface

>>> hw/rtl/keyword_value_text_parser.sv
// Pipeline: a frame-end transaction passes the input register, then parse
//   logic into the result register.
// Throughput: one transaction per cycle while the result register can take
//   frame ends; per-byte key match and times-ten accumulate are combinational.
// Reset: synchronous active-low rst_n clears frame state and reported values
//   to zero and empties both registers; there is no clearing pass.
module keyword_value_text_parser #(
  parameter int unsigned FRAME_LIMIT = 99
) (
  input  logic        clk,
  input  logic        rst_n,
  kvtp_in_if.sink     in_ch,
  kvtp_out_if.source  out_ch
);

  // Frame counter only ever holds values below FRAME_LIMIT
  localparam int unsigned CNT_W = $clog2(FRAME_LIMIT + 1);

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic       in_v_r;
  logic       in_op_r;
  logic [7:0] in_byte_r;

  // Output register
  logic        out_v_r;
  logic [31:0] out_press_r;
  logic        out_pf_r;
  logic [31:0] out_height_r;
  logic        out_hf_r;

  logic advance;
  logic in_ready;

  // A byte never produces a result, so it always advances. A frame end
  // advances only when the result register is free or being drained.
  assign advance  = (in_op_r == kvtp_pkg::OP_BYTE) || !out_v_r || out_ch.ready;
  assign in_ready = !in_v_r || advance;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      in_op_r   <= in_ch.opcode;
      in_byte_r <= in_ch.rx_byte;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame parse state
  // ---------------------------------------------------------------------------
  logic [CNT_W-1:0]     cnt_r,        cnt_nxt;
  logic                 stop_r,       stop_nxt;
  kvtp_pkg::key_pos_t   p_pos_r,      p_pos_nxt;
  logic [1:0]           p_phase_r,    p_phase_nxt;
  logic                 p_neg_r,      p_neg_nxt;
  logic [31:0]          p_acc_r,      p_acc_nxt;
  kvtp_pkg::key_pos_t   h_pos_r,      h_pos_nxt;
  logic [2:0]           h_phase_r,    h_phase_nxt;
  logic                 h_neg_r,      h_neg_nxt;
  logic [31:0]          h_acc_r,      h_acc_nxt;
  logic [31:0]          press_reg_r,  press_reg_nxt;
  logic [31:0]          height_reg_r, height_reg_nxt;

  logic do_byte;
  logic do_end;

  assign do_byte = in_v_r && (in_op_r == kvtp_pkg::OP_BYTE);
  assign do_end  = in_v_r && (in_op_r == kvtp_pkg::OP_END) && advance;

  // Character decode
  logic [7:0] c;
  logic [3:0] dig;
  logic       c_digit;
  logic       c_blank;
  logic       c_sign;

  assign c       = in_byte_r;
  assign dig     = in_byte_r[3:0];   // valid digit value when c_digit
  assign c_digit = kvtp_pkg::is_digit(c);
  assign c_blank = kvtp_pkg::is_blank(c);
  assign c_sign  = (c == kvtp_pkg::CH_PLUS) || (c == kvtp_pkg::CH_MINUS);

  // Key match steps: advance on a hit, restart at 1 on the key's first char
  kvtp_pkg::key_pos_t p_pos_step;
  kvtp_pkg::key_pos_t h_pos_step;

  always_comb begin
    if (c == kvtp_pkg::press_key_char(p_pos_r)) begin
      p_pos_step = p_pos_r + 4'd1;
    end else if (c == kvtp_pkg::press_key_char(4'd0)) begin
      p_pos_step = 4'd1;
    end else begin
      p_pos_step = 4'd0;
    end
    if (c == kvtp_pkg::height_key_char(h_pos_r)) begin
      h_pos_step = h_pos_r + 4'd1;
    end else if (c == kvtp_pkg::height_key_char(4'd0)) begin
      h_pos_step = 4'd1;
    end else begin
      h_pos_step = 4'd0;
    end
  end

  // Saturating accumulates: acc*10 + d for pressure, acc*10 + d*10 for the
  // height integer part, acc + d for the first fraction digit.
  logic [7:0]  dig_x10;
  logic [35:0] p_mac_w;
  logic [35:0] h_mac_w;
  logic [32:0] h_frac_w;
  logic [31:0] p_mac;
  logic [31:0] h_mac;
  logic [31:0] h_frac;

  assign dig_x10  = {1'b0, dig, 3'b000} + {3'b000, dig, 1'b0};
  assign p_mac_w  = {1'b0, p_acc_r, 3'b000} + {3'b000, p_acc_r, 1'b0} + {32'd0, dig};
  assign h_mac_w  = {1'b0, h_acc_r, 3'b000} + {3'b000, h_acc_r, 1'b0} + {28'd0, dig_x10};
  assign h_frac_w = {1'b0, h_acc_r} + {29'd0, dig};
  assign p_mac    = (p_mac_w > {4'd0, kvtp_pkg::MAG_CAP}) ? kvtp_pkg::MAG_CAP : p_mac_w[31:0];
  assign h_mac    = (h_mac_w > {4'd0, kvtp_pkg::MAG_CAP}) ? kvtp_pkg::MAG_CAP : h_mac_w[31:0];
  assign h_frac   = (h_frac_w > {1'b0, kvtp_pkg::MAG_CAP}) ? kvtp_pkg::MAG_CAP
                                                           : h_frac_w[31:0];

  logic [CNT_W:0] cnt_inc;
  logic           clear_frame;

  assign cnt_inc = {1'b0, cnt_r} + {{CNT_W{1'b0}}, 1'b1};

  always_comb begin
    cnt_nxt        = cnt_r;
    stop_nxt       = stop_r;
    p_pos_nxt      = p_pos_r;
    p_phase_nxt    = p_phase_r;
    p_neg_nxt      = p_neg_r;
    p_acc_nxt      = p_acc_r;
    h_pos_nxt      = h_pos_r;
    h_phase_nxt    = h_phase_r;
    h_neg_nxt      = h_neg_r;
    h_acc_nxt      = h_acc_r;
    press_reg_nxt  = press_reg_r;
    height_reg_nxt = height_reg_r;
    clear_frame    = 1'b0;

    if (do_byte) begin
      if (!stop_r) begin
        if (c == kvtp_pkg::CH_NUL) begin
          // A zero byte halts parsing for the rest of the frame
          stop_nxt = 1'b1;
        end else begin
          // Pressure: integer after the key
          case (p_phase_r)
            kvtp_pkg::PP_SEARCH: begin
              if (32'(p_pos_step) >= kvtp_pkg::PRESS_KEY_LEN) begin
                p_pos_nxt   = 4'd0;
                p_phase_nxt = kvtp_pkg::PP_BLANK;
              end else begin
                p_pos_nxt = p_pos_step;
              end
            end
            kvtp_pkg::PP_BLANK: begin
              if (c_blank) begin
                p_phase_nxt = kvtp_pkg::PP_BLANK;
              end else if (c_sign) begin
                p_neg_nxt   = (c == kvtp_pkg::CH_MINUS);
                p_phase_nxt = kvtp_pkg::PP_DIGITS;
              end else if (c_digit) begin
                p_acc_nxt   = {28'd0, dig};
                p_phase_nxt = kvtp_pkg::PP_DIGITS;
              end else begin
                p_phase_nxt = kvtp_pkg::PP_DONE;
              end
            end
            kvtp_pkg::PP_DIGITS: begin
              if (c_digit) begin
                p_acc_nxt = p_mac;
              end else begin
                p_phase_nxt = kvtp_pkg::PP_DONE;
              end
            end
            default: begin
              p_phase_nxt = p_phase_r;
            end
          endcase

          // Height: decimal number after the key, kept in tenths
          case (h_phase_r)
            kvtp_pkg::HP_SEARCH: begin
              if (32'(h_pos_step) >= kvtp_pkg::HEIGHT_KEY_LEN) begin
                h_pos_nxt   = 4'd0;
                h_phase_nxt = kvtp_pkg::HP_BLANK;
              end else begin
                h_pos_nxt = h_pos_step;
              end
            end
            kvtp_pkg::HP_BLANK: begin
              if (c_blank) begin
                h_phase_nxt = kvtp_pkg::HP_BLANK;
              end else if (c_sign) begin
                h_neg_nxt   = (c == kvtp_pkg::CH_MINUS);
                h_phase_nxt = kvtp_pkg::HP_INT;
              end else if (c_digit) begin
                h_acc_nxt   = {24'd0, dig_x10};
                h_phase_nxt = kvtp_pkg::HP_INT;
              end else if (c == kvtp_pkg::CH_DOT) begin
                h_phase_nxt = kvtp_pkg::HP_FRAC;
              end else begin
                h_phase_nxt = kvtp_pkg::HP_DONE;
              end
            end
            kvtp_pkg::HP_INT: begin
              if (c_digit) begin
                h_acc_nxt = h_mac;
              end else if (c == kvtp_pkg::CH_DOT) begin
                h_phase_nxt = kvtp_pkg::HP_FRAC;
              end else begin
                h_phase_nxt = kvtp_pkg::HP_DONE;
              end
            end
            kvtp_pkg::HP_FRAC: begin
              // Only the first fraction digit counts; drop the rest
              if (c_digit) begin
                h_acc_nxt = h_frac;
              end
              h_phase_nxt = kvtp_pkg::HP_DONE;
            end
            default: begin
              h_phase_nxt = h_phase_r;
            end
          endcase
        end
      end

      // Bytes count even after a stop; wrap the frame at the limit
      cnt_nxt = cnt_inc[CNT_W-1:0];
      if (32'(cnt_inc) >= FRAME_LIMIT) begin
        clear_frame = 1'b1;
      end
    end

    if (do_end) begin
      // Missing keys keep the previous reported value
      if (p_phase_r != kvtp_pkg::PP_SEARCH) begin
        press_reg_nxt = kvtp_pkg::to_signed_bits(p_acc_r, p_neg_r);
      end
      if (h_phase_r != kvtp_pkg::HP_SEARCH) begin
        height_reg_nxt = kvtp_pkg::to_signed_bits(h_acc_r, h_neg_r);
      end
      clear_frame = 1'b1;
    end

    if (clear_frame) begin
      cnt_nxt     = '0;
      stop_nxt    = 1'b0;
      p_pos_nxt   = 4'd0;
      p_phase_nxt = kvtp_pkg::PP_SEARCH;
      p_neg_nxt   = 1'b0;
      p_acc_nxt   = 32'd0;
      h_pos_nxt   = 4'd0;
      h_phase_nxt = kvtp_pkg::HP_SEARCH;
      h_neg_nxt   = 1'b0;
      h_acc_nxt   = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r        <= '0;
      stop_r       <= 1'b0;
      p_pos_r      <= 4'd0;
      p_phase_r    <= kvtp_pkg::PP_SEARCH;
      p_neg_r      <= 1'b0;
      p_acc_r      <= 32'd0;
      h_pos_r      <= 4'd0;
      h_phase_r    <= kvtp_pkg::HP_SEARCH;
      h_neg_r      <= 1'b0;
      h_acc_r      <= 32'd0;
      press_reg_r  <= 32'd0;
      height_reg_r <= 32'd0;
    end else begin
      cnt_r        <= cnt_nxt;
      stop_r       <= stop_nxt;
      p_pos_r      <= p_pos_nxt;
      p_phase_r    <= p_phase_nxt;
      p_neg_r      <= p_neg_nxt;
      p_acc_r      <= p_acc_nxt;
      h_pos_r      <= h_pos_nxt;
      h_phase_r    <= h_phase_nxt;
      h_neg_r      <= h_neg_nxt;
      h_acc_r      <= h_acc_nxt;
      press_reg_r  <= press_reg_nxt;
      height_reg_r <= height_reg_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: load on frame end, hold until the sink takes it
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (do_end) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_end) begin
      out_press_r  <= press_reg_nxt;
      out_pf_r     <= (p_phase_r != kvtp_pkg::PP_SEARCH);
      out_height_r <= height_reg_nxt;
      out_hf_r     <= (h_phase_r != kvtp_pkg::HP_SEARCH);
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.pressure_value = out_press_r;
  assign out_ch.pressure_found = out_pf_r;
  assign out_ch.height_tenths  = out_height_r;
  assign out_ch.height_found   = out_hf_r;

endmodule
